/* rtl/xmbr_pkg.sv */
// shared types and constants for the xmodem block receiver
// no dependencies; used by xmbr_core and xmodem_block_receiver
package xmbr_pkg;

  // data bytes per xmodem block
  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_BYTES - 1);
  localparam logic [31:0] BLOCK_SIZE = 32'(BLOCK_BYTES);

  // serial control characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] BLK_CHECK_OK = 8'hff;

  // request kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ABORTED  = 2'd2;

  // receiver phases
  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_BLKNUM   = 3'd1;
  localparam logic [2:0] PH_BLKCOMP  = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_CHECK    = 3'd4;
  localparam logic [2:0] PH_FINISHED = 3'd5;
  localparam logic [2:0] PH_ABORTED  = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic [1:0]  status;
    logic [31:0] total_size;
  } out_item_t;

endpackage

/* rtl/xmbr_core.sv */
// receiver state and per-request step logic for the xmodem block receiver
// depends on xmbr_pkg
module xmbr_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  xmbr_pkg::in_item_t  item,
  input  logic [31:0]         load_base,
  output xmbr_pkg::out_item_t result
);

  logic [2:0]                 phase, phase_next;
  logic [7:0]                 block_check, block_check_next;
  logic [xmbr_pkg::IDX_W-1:0] data_index, data_index_next;
  logic [7:0]                 running_sum, running_sum_next;
  logic [31:0]                accepted_size, accepted_size_next;

  always_comb begin
    phase_next         = phase;
    block_check_next   = block_check;
    data_index_next    = data_index;
    running_sum_next   = running_sum;
    accepted_size_next = accepted_size;
    result             = '0;

    if (item.kind == xmbr_pkg::KIND_START) begin
      phase_next         = xmbr_pkg::PH_HEADER;
      block_check_next   = '0;
      data_index_next    = '0;
      running_sum_next   = '0;
      accepted_size_next = '0;
      result.reply_valid = 1'b1;
      result.reply_byte  = xmbr_pkg::CH_NAK;
    end else begin
      unique case (phase)
        xmbr_pkg::PH_HEADER: begin
          if (item.rx_byte == xmbr_pkg::CH_EOT) begin
            result.reply_valid = 1'b1;
            result.reply_byte  = xmbr_pkg::CH_ACK;
            phase_next         = xmbr_pkg::PH_FINISHED;
          end else if (item.rx_byte == xmbr_pkg::CH_SOH) begin
            phase_next = xmbr_pkg::PH_BLKNUM;
          end else begin
            accepted_size_next = '0;
            phase_next         = xmbr_pkg::PH_ABORTED;
          end
        end
        xmbr_pkg::PH_BLKNUM: begin
          block_check_next = item.rx_byte;
          phase_next       = xmbr_pkg::PH_BLKCOMP;
        end
        xmbr_pkg::PH_BLKCOMP: begin
          block_check_next = block_check ^ item.rx_byte;
          if ((block_check ^ item.rx_byte) != xmbr_pkg::BLK_CHECK_OK) begin
            result.reply_valid = 1'b1;
            result.reply_byte  = xmbr_pkg::CH_NAK;
            phase_next         = xmbr_pkg::PH_HEADER;
          end else begin
            data_index_next  = '0;
            running_sum_next = '0;
            phase_next       = xmbr_pkg::PH_DATA;
          end
        end
        xmbr_pkg::PH_DATA: begin
          result.write_valid   = 1'b1;
          result.write_address = load_base + accepted_size + 32'(data_index);
          result.write_data    = item.rx_byte;
          running_sum_next     = running_sum + item.rx_byte;
          if (data_index == xmbr_pkg::IDX_LAST) begin
            data_index_next = '0;
            phase_next      = xmbr_pkg::PH_CHECK;
          end else begin
            data_index_next = data_index + 1'b1;
          end
        end
        xmbr_pkg::PH_CHECK: begin
          result.reply_valid = 1'b1;
          if (running_sum == item.rx_byte) begin
            result.reply_byte  = xmbr_pkg::CH_ACK;
            accepted_size_next = accepted_size + xmbr_pkg::BLOCK_SIZE;
          end else begin
            result.reply_byte = xmbr_pkg::CH_NAK;
          end
          data_index_next = '0;
          phase_next      = xmbr_pkg::PH_HEADER;
        end
        default: begin
          // finished or aborted: bytes are ignored until the next start
        end
      endcase
    end

    if (phase_next == xmbr_pkg::PH_FINISHED) begin
      result.status = xmbr_pkg::ST_FINISHED;
    end else if (phase_next == xmbr_pkg::PH_ABORTED) begin
      result.status = xmbr_pkg::ST_ABORTED;
    end else begin
      result.status = xmbr_pkg::ST_RUNNING;
    end
    result.total_size = accepted_size_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= xmbr_pkg::PH_HEADER;
      block_check   <= '0;
      data_index    <= '0;
      running_sum   <= '0;
      accepted_size <= '0;
    end else if (step) begin
      phase         <= phase_next;
      block_check   <= block_check_next;
      data_index    <= data_index_next;
      running_sum   <= running_sum_next;
      accepted_size <= accepted_size_next;
    end
  end

endmodule

/* rtl/xmodem_block_receiver.sv */
// top level of the xmodem block receiver: request register, result register, load_base
// depends on xmbr_pkg and xmbr_core
//
//   channel  direction  handshake              payload
//   in       in         in_valid / in_stall    in_item  (kind, rx_byte)
//   out      out        out_valid / out_stall  out_item (write, reply, status, size)
//   config   in         load_base_we           load_base_wdata
//
// one request per cycle sustained while out_stall is low
// the request register feeds the step logic, whose result lands in the result register
// rst is synchronous and active high; it clears the receiver state and load_base
// out_stall holds the result register and, once the request register is full, raises in_stall
// a request waiting in the request register is taken as soon as the result register frees
module xmodem_block_receiver (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  xmbr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output xmbr_pkg::out_item_t out_item,
  input  logic                load_base_we,
  input  logic [31:0]         load_base_wdata
);

  // request register
  logic                s1_valid;
  xmbr_pkg::in_item_t  s1_item;
  // load address register
  logic [31:0]         load_base;
  // step result for the request in s1
  xmbr_pkg::out_item_t result;
  logic                advance;

  // the request in s1 moves on when the result register is empty or draining
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base <= '0;
    end else if (load_base_we) begin
      load_base <= load_base_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  xmbr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (s1_item),
    .load_base (load_base),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

  // a step never both writes memory and sends a reply
  a_write_or_reply: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.write_valid |-> !out_item.reply_valid)
    else $error("write and reply in the same result");

  // an abort always reports zero accepted bytes
  a_abort_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == xmbr_pkg::ST_ABORTED) |-> (out_item.total_size == '0))
    else $error("aborted with nonzero size");

  // data writes only happen while the transfer is running
  a_write_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.write_valid |-> (out_item.status == xmbr_pkg::ST_RUNNING))
    else $error("write outside a running transfer");

  // a request leaving s1 always shows up as a result next cycle
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request step lost");

endmodule
